>>> rtl/core/ptb_pkg.sv
// shared types, widths and constants for the polar table speed lookup
package ptb_pkg;

  // table geometry
  localparam int NUM_TYPES     = 8;
  localparam int ANGLE_ROWS    = 19;
  localparam int SPEED_COLS    = 7;
  localparam int TABLE_ENTRIES = ANGLE_ROWS * SPEED_COLS;

  // field widths
  localparam int TYPE_IN_W = 4;
  localparam int EIDX_W    = 8;
  localparam int EV_W      = 16;
  localparam int WS_W      = 14;
  localparam int ANG_W     = 16;
  localparam int OUT_W     = 18;

  // internal widths
  localparam int TYPE_W  = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int ROW_W   = $clog2(ANGLE_ROWS + 1);
  localparam int COL_W   = 3;
  localparam int BANK_AW = TYPE_W + (ROW_W - 1) + (COL_W - 1);
  localparam int AW_W    = 10;
  localparam int SW_W    = 11;
  localparam int WSP_W   = 12;
  localparam int RV_W    = 28;
  localparam int ACC_W   = 38;
  localparam int PROD_W  = 52;

  // angle constants, 1/64 degree
  localparam int ROW_STEP  = 640;
  localparam int ROW_SH    = 7;
  localparam int HALF_TURN = 11520;
  localparam int FULL_FOLD = 2 * HALF_TURN;
  localparam int ANGLE_MAX = (ANGLE_ROWS - 1) * ROW_STEP;
  localparam int REC5A_K   = 205;
  localparam int REC5A_SH  = 10;

  // speed breakpoints, 1/256 m/s
  localparam int SPD_1   = 256;
  localparam int SPD_2   = 512;
  localparam int SPD_4   = 1024;
  localparam int SPD_8   = 2048;
  localparam int SPD_12  = 3072;
  localparam int SPD_16  = 4096;
  localparam int SPD_24  = 6144;
  localparam int SPD_ONE = 2048;

  // entry index split by seven
  localparam int REC7_K  = 2341;
  localparam int REC7_SH = 14;
  localparam int REC7_W  = 20;

  // final scaling: divide by 2^30 then by 5, floor, saturate
  localparam int SHIFT    = 30;
  localparam int X_W      = PROD_W - SHIFT;
  localparam int SAT_HI   = 655359;
  localparam int SAT_LO   = -655360;
  localparam int OFFS     = 655360;
  localparam int Y_W      = 21;
  localparam int DIV5_K   = 1677722;
  localparam int DIV5_SH  = 23;
  localparam int Q_W      = 2 * Y_W - DIV5_SH;
  localparam int OUT_BIAS = 131072;

  // pipeline depth
  localparam int STAGES = 8;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_SPEED = 1'b1
  } ptb_op_t;

  // one input beat
  typedef struct packed {
    ptb_op_t                op;
    logic [TYPE_IN_W-1:0]   table_type;
    logic [EIDX_W-1:0]      entry_index;
    logic signed [EV_W-1:0] entry_value;
    logic [WS_W-1:0]        wind_speed;
    logic signed [ANG_W-1:0] wind_angle;
  } ptb_req_t;

  // after angle fold and speed segment
  typedef struct packed {
    ptb_op_t             op;
    logic                unk;
    logic [TYPE_W-1:0]   ttype;
    logic                wr_ok;
    logic [ROW_W-1:0]    wrow;
    logic [COL_W-1:0]    wcol;
    logic [EV_W-1:0]     wdata;
    logic [ANG_W-1:0]    ang;
    logic [COL_W-1:0]    col;
    logic [SW_W-1:0]     sw;
    logic [WS_W-1:0]     ws;
  } ptb_s1_t;

  // row, column and weights ready for table access
  typedef struct packed {
    ptb_op_t             op;
    logic                unk;
    logic [TYPE_W-1:0]   ttype;
    logic                wr_ok;
    logic [EV_W-1:0]     wdata;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [AW_W-1:0]     aw;
    logic [SW_W-1:0]     sw;
    logic [WS_W-1:0]     ws;
  } ptb_s2_t;

  // alongside the bank read data
  typedef struct packed {
    ptb_op_t             op;
    logic                unk;
    logic                rpar;
    logic                cpar;
    logic [AW_W-1:0]     aw;
    logic [SW_W-1:0]     sw;
    logic [WS_W-1:0]     ws;
  } ptb_s3_t;

endpackage

>>> rtl/core/ptb_if.sv
// valid/ready channel interfaces for request and result beats
interface ptb_in_if import ptb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [TYPE_IN_W-1:0]    table_type;
  logic [EIDX_W-1:0]       entry_index;
  logic signed [EV_W-1:0]  entry_value;
  logic [WS_W-1:0]         wind_speed;
  logic signed [ANG_W-1:0] wind_angle;

  modport source (
    output valid, op, table_type, entry_index, entry_value, wind_speed, wind_angle,
    input  ready
  );
  modport sink (
    input  valid, op, table_type, entry_index, entry_value, wind_speed, wind_angle,
    output ready
  );
endinterface

interface ptb_out_if import ptb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] boat_speed;
  logic                    unknown_type;

  modport source (
    output valid, boat_speed, unknown_type,
    input  ready
  );
  modport sink (
    input  valid, boat_speed, unknown_type,
    output ready
  );
endinterface

>>> rtl/core/ptb_ram.sv
// single-port table bank with registered read
module ptb_ram #(
  parameter int ADDR_W = 9,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0] rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  // read port, holds while stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/ptb_front.sv
// front stages: angle fold, speed segment, write decode, row and angle weight
module ptb_front import ptb_pkg::*; (
  input  logic       clk,
  input  logic [1:0] stage_en,
  input  ptb_req_t   req,
  output ptb_s2_t    s2
);

  localparam logic signed [ANG_W:0] FOLD_ONE = (ANG_W+1)'(HALF_TURN);
  localparam logic signed [ANG_W:0] FOLD_TWO = (ANG_W+1)'(FULL_FOLD);

  ptb_s1_t s1_nxt, s1_r;
  ptb_s2_t s2_nxt, s2_r;

  logic signed [ANG_W:0]  ang_x;
  logic signed [ANG_W:0]  ang_f;
  logic [ANG_W-1:0]       ang_abs;
  logic [REC7_W-1:0]      m7;
  logic [EIDX_W-1:0]      wrow_full;
  logic [7:0]             ax;
  logic [ANG_W-1:0]       m5;
  logic [ANG_W-1:0]       arow;
  logic [ANG_W-1:0]       aw_full;

  // stage 1: fold angle, find speed segment, split the write index
  always_comb begin
    s1_nxt       = '0;
    s1_nxt.op    = req.op;
    s1_nxt.unk   = ({1'b0, req.table_type} >= (TYPE_IN_W+1)'(NUM_TYPES));
    s1_nxt.ttype = req.table_type[TYPE_W-1:0];
    s1_nxt.wdata = req.entry_value;
    s1_nxt.ws    = req.wind_speed;

    // angle fold to 0..180 degrees, then clamp to the last row
    ang_x = (ANG_W+1)'(req.wind_angle);
    if (ang_x > FOLD_TWO) begin
      ang_f = ang_x - FOLD_TWO;
    end else if (ang_x > FOLD_ONE) begin
      ang_f = ang_x - FOLD_ONE;
    end else begin
      ang_f = ang_x;
    end
    ang_abs = ang_f[ANG_W] ? ANG_W'(-ang_f) : ANG_W'(ang_f);
    s1_nxt.ang = (ang_abs > ANG_W'(ANGLE_MAX)) ? ANG_W'(ANGLE_MAX) : ang_abs;

    // speed segment and offset scaled to 1/2048
    if (req.wind_speed >= WS_W'(SPD_24)) begin
      s1_nxt.col = 3'd6;
      s1_nxt.sw  = '0;
    end else if (req.wind_speed >= WS_W'(SPD_16)) begin
      s1_nxt.col = 3'd5;
      s1_nxt.sw  = SW_W'(req.wind_speed - WS_W'(SPD_16));
    end else if (req.wind_speed >= WS_W'(SPD_12)) begin
      s1_nxt.col = 3'd4;
      s1_nxt.sw  = SW_W'((req.wind_speed - WS_W'(SPD_12)) << 1);
    end else if (req.wind_speed >= WS_W'(SPD_8)) begin
      s1_nxt.col = 3'd3;
      s1_nxt.sw  = SW_W'((req.wind_speed - WS_W'(SPD_8)) << 1);
    end else if (req.wind_speed >= WS_W'(SPD_4)) begin
      s1_nxt.col = 3'd2;
      s1_nxt.sw  = SW_W'((req.wind_speed - WS_W'(SPD_4)) << 1);
    end else if (req.wind_speed >= WS_W'(SPD_2)) begin
      s1_nxt.col = 3'd1;
      s1_nxt.sw  = SW_W'((req.wind_speed - WS_W'(SPD_2)) << 2);
    end else if (req.wind_speed >= WS_W'(SPD_1)) begin
      s1_nxt.col = 3'd0;
      s1_nxt.sw  = SW_W'((req.wind_speed - WS_W'(SPD_1)) << 3);
    end else begin
      s1_nxt.col = 3'd0;
      s1_nxt.sw  = '0;
    end

    // write index into row and column by reciprocal of seven
    m7          = REC7_W'(req.entry_index) * REC7_W'(REC7_K);
    wrow_full   = EIDX_W'(m7 >> REC7_SH);
    s1_nxt.wrow = wrow_full[ROW_W-1:0];
    s1_nxt.wcol = COL_W'(req.entry_index - wrow_full * EIDX_W'(SPEED_COLS));
    s1_nxt.wr_ok = (req.op == OP_WRITE) && !s1_nxt.unk &&
                   ({1'b0, req.entry_index} < (EIDX_W+1)'(TABLE_ENTRIES));
  end

  // stage 2: angle row and remainder, pick row and column for the access
  always_comb begin
    ax      = 8'(s1_r.ang >> ROW_SH);
    m5      = ANG_W'(ax) * ANG_W'(REC5A_K);
    arow    = m5 >> REC5A_SH;
    aw_full = s1_r.ang - arow * ANG_W'(ROW_STEP);

    s2_nxt       = '0;
    s2_nxt.op    = s1_r.op;
    s2_nxt.unk   = s1_r.unk;
    s2_nxt.ttype = s1_r.ttype;
    s2_nxt.wr_ok = s1_r.wr_ok;
    s2_nxt.wdata = s1_r.wdata;
    s2_nxt.aw    = AW_W'(aw_full);
    s2_nxt.sw    = s1_r.sw;
    s2_nxt.ws    = s1_r.ws;
    if (s1_r.op == OP_SPEED) begin
      s2_nxt.row = arow[ROW_W-1:0];
      s2_nxt.col = s1_r.col;
    end else begin
      s2_nxt.row = s1_r.wrow;
      s2_nxt.col = s1_r.wcol;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      s1_r <= s1_nxt;
    end
    if (stage_en[1]) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2 = s2_r;

endmodule

>>> rtl/core/ptb_mac.sv
// back stages: bilinear blend, speed product, floor scale and saturation
module ptb_mac import ptb_pkg::*; (
  input  logic                    clk,
  input  logic [4:0]              stage_en,
  input  ptb_s3_t                 s3,
  input  logic signed [EV_W-1:0]  bank_rd [4],
  output logic signed [OUT_W-1:0] boat_speed,
  output logic                    unknown_type
);

  localparam logic signed [X_W-1:0] X_HI = X_W'(SAT_HI);
  localparam logic signed [X_W-1:0] X_LO = X_W'(SAT_LO);
  localparam logic signed [X_W-1:0] X_OF = X_W'(OFFS);

  // stage 4 signals
  logic signed [EV_W-1:0]  e00, e01, e10, e11;
  logic [WSP_W-1:0]        ws0, ws1;
  logic signed [RV_W-1:0]  rv0_nxt, rv1_nxt, rv0_r, rv1_r;
  logic [AW_W-1:0]         wa0_r, wa1_r;
  logic [WS_W-1:0]         ws4_r, ws5_r;
  logic                    unk4_r, unk5_r, unk6_r, unk7_r;

  // stage 5..8 signals
  logic signed [ACC_W-1:0]  acc_nxt, acc_r;
  logic signed [PROD_W-1:0] prod_nxt, prod_r;
  logic signed [X_W-1:0]    x_raw, x_sat;
  logic [Y_W-1:0]           y_nxt, y_r;
  logic [2*Y_W-1:0]         m_div;
  logic [Q_W-1:0]           q_t;
  logic signed [OUT_W-1:0]  bs_nxt, bs_r;
  logic                     unk_out_r;

  // stage 4: route banks to corners, drop zero-weight corners, blend along speed
  always_comb begin
    e00 = bank_rd[{s3.rpar, s3.cpar}];
    e01 = (s3.sw != '0) ? bank_rd[{s3.rpar, ~s3.cpar}] : '0;
    e10 = (s3.aw != '0) ? bank_rd[{~s3.rpar, s3.cpar}] : '0;
    e11 = ((s3.aw != '0) && (s3.sw != '0)) ? bank_rd[{~s3.rpar, ~s3.cpar}] : '0;
    ws1 = WSP_W'(s3.sw);
    ws0 = WSP_W'(SPD_ONE) - ws1;
    rv0_nxt = e00 * $signed({1'b0, ws0}) + e01 * $signed({1'b0, ws1});
    rv1_nxt = e10 * $signed({1'b0, ws0}) + e11 * $signed({1'b0, ws1});
  end

  // stage 5: blend along angle
  assign acc_nxt = rv0_r * $signed({1'b0, wa0_r}) + rv1_r * $signed({1'b0, wa1_r});

  // stage 6: times wind speed
  assign prod_nxt = acc_r * $signed({1'b0, ws5_r});

  // stage 7: floor by 2^30, clamp so the divide by five lands in range, bias positive
  always_comb begin
    x_raw = prod_r[PROD_W-1:SHIFT];
    if (x_raw > X_HI) begin
      x_sat = X_HI;
    end else if (x_raw < X_LO) begin
      x_sat = X_LO;
    end else begin
      x_sat = x_raw;
    end
    y_nxt = Y_W'(x_sat + X_OF);
  end

  // stage 8: divide by five via reciprocal, remove bias, zero for an unknown table
  always_comb begin
    m_div  = (2*Y_W)'(y_r) * (2*Y_W)'(DIV5_K);
    q_t    = m_div[2*Y_W-1:DIV5_SH];
    bs_nxt = unk7_r ? '0 : OUT_W'(q_t - Q_W'(OUT_BIAS));
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      rv0_r  <= rv0_nxt;
      rv1_r  <= rv1_nxt;
      wa0_r  <= AW_W'(ROW_STEP) - s3.aw;
      wa1_r  <= s3.aw;
      ws4_r  <= s3.ws;
      unk4_r <= s3.unk;
    end
    if (stage_en[1]) begin
      acc_r  <= acc_nxt;
      ws5_r  <= ws4_r;
      unk5_r <= unk4_r;
    end
    if (stage_en[2]) begin
      prod_r <= prod_nxt;
      unk6_r <= unk5_r;
    end
    if (stage_en[3]) begin
      y_r    <= y_nxt;
      unk7_r <= unk6_r;
    end
    if (stage_en[4]) begin
      bs_r      <= bs_nxt;
      unk_out_r <= unk7_r;
    end
  end

  assign boat_speed   = bs_r;
  assign unknown_type = unk_out_r;

endmodule

>>> rtl/core/polar_table_bilinear_speed_unit.sv
// top level: polar response tables with bilinear speed lookup
//
//  channel  | dir | beat                                              | result
//  ---------+-----+---------------------------------------------------+----------------
//  in_ch    | in  | op, table_type, entry_index, entry_value,         | write: none
//           |     | wind_speed, wind_angle                            | speed: one beat
//  out_ch   | out | boat_speed, unknown_type                          | -
//
// one beat enters per cycle while in_ch.ready is high; a speed beat passes through
// the eight register stages (two front, one table bank read, five arithmetic).
// the table is four banks split by row and column parity, so the four corner
// reads of one beat share a single cycle; writes go through the same stage.
// tables are undefined after reset, so there is no clearing pass; reset only
// empties the pipeline. each stage has its own valid bit and bubbles close up
// under stall; in_ch.ready drops only when all eight stages hold a beat.
module polar_table_bilinear_speed_unit import ptb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ptb_in_if.sink    in_ch,
  ptb_out_if.source out_ch
);

  logic [STAGES:1] v_r, v_in, en;

  ptb_req_t req;
  ptb_s2_t  s2;
  ptb_s3_t  s3_nxt, s3_r;

  logic signed [EV_W-1:0] bank_rd [4];
  logic                   wr_go;

  // stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    en[STAGES] = !v_r[STAGES] || out_ch.ready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  // valid bits; write beats end at the table stage
  always_comb begin
    v_in[1] = in_ch.valid;
    v_in[2] = v_r[1];
    v_in[3] = v_r[2];
    v_in[4] = v_r[3] && (s3_r.op == OP_SPEED);
    for (int k = 5; k <= STAGES; k++) begin
      v_in[k] = v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  assign in_ch.ready = en[1];

  // request beat
  always_comb begin
    req.op          = ptb_op_t'(in_ch.op);
    req.table_type  = in_ch.table_type;
    req.entry_index = in_ch.entry_index;
    req.entry_value = in_ch.entry_value;
    req.wind_speed  = in_ch.wind_speed;
    req.wind_angle  = in_ch.wind_angle;
  end

  ptb_front u_front (
    .clk      (clk),
    .stage_en (en[2:1]),
    .req      (req),
    .s2       (s2)
  );

  // table stage: four parity banks, one address each per cycle while en[3] is high
  assign wr_go = en[3] && v_r[2] && s2.wr_ok;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic RP = 1'((b >> 1) & 1);
    localparam logic CP = 1'(b & 1);

    logic [ROW_W-1:0]   rr;
    logic [COL_W-1:0]   cc;
    logic [BANK_AW-1:0] addr;
    logic               we;
    logic [EV_W-1:0]    rd_raw;

    // the neighbor row and column that land in this bank
    assign rr   = s2.row + ROW_W'(RP ^ s2.row[0]);
    assign cc   = s2.col + COL_W'(CP ^ s2.col[0]);
    assign addr = {s2.ttype, rr[ROW_W-1:1], cc[COL_W-1:1]};
    assign we   = wr_go && (s2.row[0] == RP) && (s2.col[0] == CP);

    ptb_ram #(
      .ADDR_W (BANK_AW),
      .DATA_W (EV_W)
    ) u_ram (
      .clk     (clk),
      .rd_en   (en[3]),
      .wr_en   (we),
      .addr    (addr),
      .wr_data (s2.wdata),
      .rd_data (rd_raw)
    );

    assign bank_rd[b] = $signed(rd_raw);
  end

  // payload beside the read data
  always_comb begin
    s3_nxt.op   = s2.op;
    s3_nxt.unk  = s2.unk;
    s3_nxt.rpar = s2.row[0];
    s3_nxt.cpar = s2.col[0];
    s3_nxt.aw   = s2.aw;
    s3_nxt.sw   = s2.sw;
    s3_nxt.ws   = s2.ws;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_r <= s3_nxt;
    end
  end

  ptb_mac u_mac (
    .clk          (clk),
    .stage_en     (en[STAGES:4]),
    .s3           (s3_r),
    .bank_rd      (bank_rd),
    .boat_speed   (out_ch.boat_speed),
    .unknown_type (out_ch.unknown_type)
  );

  assign out_ch.valid = v_r[STAGES];

  // back-pressure reaches the input only when every stage is occupied
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&v_r))
    else $error("input stalled with an empty stage");

  // write beats never reach the arithmetic stages
  a_write_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (en[4] && v_r[3] && (s3_r.op == OP_WRITE)) |=> !v_r[4])
    else $error("write beat entered the arithmetic stages");

  // a held stage keeps its beat
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[5] && !en[5]) |=> v_r[5])
    else $error("stalled stage lost its beat");

  // unknown table gives zero speed
  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.unknown_type) |-> (out_ch.boat_speed == '0))
    else $error("unknown table type with nonzero speed");

endmodule
